FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// immediate relation that must hold at every clock edge out of reset
`define TCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define TCF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: design/tcf_pkg.sv
`timescale 1ns / 1ps

package tcf_pkg;

  localparam int BYTE_W = 8;

  // telnet command codes
  localparam logic [BYTE_W-1:0] CMD_WILL = 8'hFB;
  localparam logic [BYTE_W-1:0] CMD_WONT = 8'hFC;
  localparam logic [BYTE_W-1:0] CMD_DO   = 8'hFD;
  localparam logic [BYTE_W-1:0] CMD_DONT = 8'hFE;
  localparam logic [BYTE_W-1:0] CMD_IAC  = 8'hFF;
  localparam logic [BYTE_W-1:0] OPT_GA   = 8'hF9;
  localparam logic [BYTE_W-1:0] BYTE_NUL = 8'h00;

  // parser phase codes
  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_CMD  = 2'd1;
  localparam logic [1:0] PH_OPT  = 2'd2;

  // position inside a three-byte reply
  localparam logic [1:0] IDX_IAC = 2'd0;
  localparam logic [1:0] IDX_CMD = 2'd1;
  localparam logic [1:0] IDX_OPT = 2'd2;

  // what one received byte produces
  typedef struct packed {
    logic              emit;
    logic              is_reply;
    logic [BYTE_W-1:0] byte_val;
    logic [BYTE_W-1:0] reply_cmd;
  } tcf_result_t;

endpackage

FILE: design/tcf_in_if.sv
`timescale 1ns / 1ps

interface tcf_in_if import tcf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: design/tcf_out_if.sv
`timescale 1ns / 1ps

interface tcf_out_if import tcf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              to_peer;
  logic              last;

  modport source (output valid, output out_byte, output to_peer, output last, input ready);
  modport sink   (input valid, input out_byte, input to_peer, input last, output ready);
endinterface

FILE: design/telnet_command_filter.sv
`timescale 1ns / 1ps

// Telnet receive filter. Takes one received byte per transaction on in_chan and
// strips Telnet control sequences: NUL is dropped, IAC IAC gives one 0xFF data
// byte, IAC with another command is dropped, and IAC WILL/WONT/DO/DONT plus an
// option byte is dropped and answered on out_chan with three reply bytes
// (to_peer = 1). Data bytes and 0xFF are passed with to_peer = 0; last marks
// the final byte produced by one input. Each input byte is held in an
// input register, is parsed there, and its result is loaded into the output
// register; a new byte is taken every cycle while plain data flows and out_chan
// is ready. A reply holds the output register for three transactions, so the
// byte after a negotiation waits until the reply's last byte is taken; bytes
// that produce nothing pass through even while a result waits on out_chan.
module telnet_command_filter import tcf_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  tcf_in_if.sink   in_chan,
  tcf_out_if.source out_chan
);

`include "assert_macros.svh"

  // input register
  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;

  // parser state
  logic [1:0] phase_r, phase_nxt;
  logic       held_is_do_r, held_is_do_nxt;

  // result register
  logic              res_vld_r;
  logic              res_is_reply_r;
  logic [1:0]        res_idx_r;
  logic [BYTE_W-1:0] res_byte_r;
  logic [BYTE_W-1:0] res_cmd_r;

  tcf_result_t parse;
  logic        slot_free;
  logic        advance;
  logic        out_last;

  // parse the registered byte against the current phase
  always_comb begin
    parse          = '0;
    parse.byte_val = in_byte_r;
    phase_nxt      = phase_r;
    held_is_do_nxt = held_is_do_r;
    case (phase_r)
      PH_CMD: begin
        phase_nxt = PH_DATA;
        if (in_byte_r == CMD_IAC) begin
          parse.emit = 1'b1;
        end else if (in_byte_r == CMD_WILL || in_byte_r == CMD_WONT ||
                     in_byte_r == CMD_DO || in_byte_r == CMD_DONT) begin
          held_is_do_nxt = (in_byte_r == CMD_DO);
          phase_nxt      = PH_OPT;
        end
      end
      PH_OPT: begin
        parse.emit     = 1'b1;
        parse.is_reply = 1'b1;
        if (in_byte_r == OPT_GA) begin
          parse.reply_cmd = held_is_do_r ? CMD_WILL : CMD_DO;
        end else begin
          parse.reply_cmd = held_is_do_r ? CMD_WONT : CMD_DONT;
        end
        phase_nxt      = PH_DATA;
        held_is_do_nxt = 1'b0;
      end
      default: begin
        phase_nxt = PH_DATA;
        if (in_byte_r == CMD_IAC) begin
          phase_nxt = PH_CMD;
        end else if (in_byte_r != BYTE_NUL) begin
          parse.emit = 1'b1;
        end
      end
    endcase
  end

  // output side view of the result register
  assign out_last  = !res_is_reply_r || (res_idx_r == IDX_OPT);
  assign slot_free = !res_vld_r || (out_chan.ready && out_last);
  assign advance   = in_vld_r && (!parse.emit || slot_free);

  assign in_chan.ready = !in_vld_r || advance;

  always_comb begin
    out_chan.valid   = res_vld_r;
    out_chan.to_peer = res_is_reply_r;
    out_chan.last    = out_last;
    out_chan.out_byte = res_byte_r;
    if (res_is_reply_r) begin
      case (res_idx_r)
        IDX_IAC: out_chan.out_byte = CMD_IAC;
        IDX_CMD: out_chan.out_byte = res_cmd_r;
        default: out_chan.out_byte = res_byte_r;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.rx_byte;
    end
  end

  // parser state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_DATA;
      held_is_do_r <= 1'b0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      held_is_do_r <= held_is_do_nxt;
    end
  end

  // result register and reply sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r      <= 1'b0;
      res_idx_r      <= IDX_IAC;
      res_is_reply_r <= 1'b0;
    end else if (advance && parse.emit) begin
      res_vld_r      <= 1'b1;
      res_idx_r      <= IDX_IAC;
      res_is_reply_r <= parse.is_reply;
    end else if (res_vld_r && out_chan.ready) begin
      if (out_last) begin
        res_vld_r <= 1'b0;
      end else begin
        res_idx_r <= res_idx_r + 2'd1;
      end
    end
    if (advance && parse.emit) begin
      res_byte_r <= parse.byte_val;
      res_cmd_r  <= parse.reply_cmd;
    end
  end

  // checks
  `TCF_ASSERT(a_data_single, !(res_vld_r && !res_is_reply_r && res_idx_r != IDX_IAC),
              "data result left the first position")
  `TCF_ASSERT_NEXT(a_reply_holds, out_chan.valid && !(out_chan.ready && out_chan.last),
                   out_chan.valid, "result dropped before its last transaction")
  `TCF_ASSERT_NEXT(a_opt_reply, advance && phase_r == PH_OPT,
                   res_vld_r && res_is_reply_r && res_idx_r == IDX_IAC && phase_r == PH_DATA,
                   "option byte did not start a reply")
  `TCF_ASSERT(a_no_overwrite,
              !(advance && parse.emit && res_vld_r && !(out_chan.ready && out_last)),
              "result register overwritten while busy")

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tcf_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 100;
  localparam int SETTLE_TIME  = 20;

  // one byte waiting to be sent to the filter
  typedef struct {
    logic [BYTE_W-1:0] value;
    bit                drain_first;
    int                gap_after;
  } rx_item_t;

  // one byte the filter is expected to hand out
  typedef struct {
    logic [BYTE_W-1:0] out_byte;
    logic              to_peer;
    logic              last;
  } filtered_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tcf_in_if  in_chan ();
  tcf_out_if out_chan ();

  telnet_command_filter u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  rx_item_t  rx_stream[$];
  filtered_t expected_bytes[$];

  // predicted parser state
  logic [1:0] parse_phase = PH_DATA;
  logic       held_is_do = 1'b0;

  int   error_count = 0;
  int   cycle_count = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   calm_left = 0;
  logic in_taken = 1'b0;

  always #1 clk = ~clk;

  task automatic report_error(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void add_rx(input logic [BYTE_W-1:0] value, input bit drain_first = 0);
    rx_item_t item;
    item.value = value;
    item.drain_first = drain_first;
    if (calm_left == 0 && $urandom_range(99) < 12) calm_left = $urandom_range(10, 25);
    if (calm_left != 0) begin
      calm_left--;
      item.gap_after = 0;
    end else begin
      item.gap_after = pick_gap();
    end
    rx_stream.push_back(item);
  endfunction

  function automatic logic [BYTE_W-1:0] random_negotiation_cmd();
    case ($urandom_range(3))
      0: return CMD_WILL;
      1: return CMD_WONT;
      2: return CMD_DO;
      default: return CMD_DONT;
    endcase
  endfunction

  function automatic void queue_result(input logic [BYTE_W-1:0] value, input logic peer,
                                       input logic fin);
    filtered_t res;
    res.out_byte = value;
    res.to_peer = peer;
    res.last = fin;
    expected_bytes.push_back(res);
  endfunction

  // telnet receive parser: strips control sequences, answers negotiation
  function automatic void filter_rx_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] reply;
    case (parse_phase)
      PH_CMD: begin
        if (b == CMD_IAC) begin
          parse_phase = PH_DATA;
          queue_result(CMD_IAC, 1'b0, 1'b1);
        end else if (b == CMD_WILL || b == CMD_WONT || b == CMD_DO || b == CMD_DONT) begin
          held_is_do = (b == CMD_DO);
          parse_phase = PH_OPT;
        end else begin
          parse_phase = PH_DATA;
        end
      end
      PH_OPT: begin
        if (b == OPT_GA) reply = held_is_do ? CMD_WILL : CMD_DO;
        else reply = held_is_do ? CMD_WONT : CMD_DONT;
        parse_phase = PH_DATA;
        held_is_do = 1'b0;
        queue_result(CMD_IAC, 1'b1, 1'b0);
        queue_result(reply, 1'b1, 1'b0);
        queue_result(b, 1'b1, 1'b1);
      end
      default: begin
        // plain data, also the unused phase code
        parse_phase = PH_DATA;
        if (b == CMD_IAC) parse_phase = PH_CMD;
        else if (b != BYTE_NUL) queue_result(b, 1'b0, 1'b1);
      end
    endcase
  endfunction

  // sample both channels; predict accepted input, check accepted output
  always @(posedge clk) begin
    filtered_t exp_res;
    in_taken <= in_chan.valid && in_chan.ready;
    if (rst_n && in_chan.valid && in_chan.ready) filter_rx_byte(in_chan.rx_byte);
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_bytes.size() == 0) begin
        report_error($sformatf("unexpected output byte %02h to_peer %0b last %0b",
                               out_chan.out_byte, out_chan.to_peer, out_chan.last));
      end else begin
        exp_res = expected_bytes.pop_front();
        if (out_chan.out_byte !== exp_res.out_byte || out_chan.to_peer !== exp_res.to_peer ||
            out_chan.last !== exp_res.last)
          report_error($sformatf("got byte %02h to_peer %0b last %0b, expected %02h %0b %0b",
                                 out_chan.out_byte, out_chan.to_peer, out_chan.last,
                                 exp_res.out_byte, exp_res.to_peer, exp_res.last));
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.rx_byte <= '0;
    end else if (!in_chan.valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_chan.valid <= 1'b0;
      end else if (rx_stream.size() != 0 &&
                   (!rx_stream[0].drain_first || expected_bytes.size() == 0)) begin
        in_chan.valid <= 1'b1;
        in_chan.rx_byte <= rx_stream[0].value;
        gap_left <= rx_stream[0].gap_after;
        void'(rx_stream.pop_front());
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // output backpressure, with stall-free stretches
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_chan.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_chan.ready <= 1'b1;
      if (cycle_count[8:7] != 2'b00) stall_left <= pick_gap();
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int sent;
    int kind;
    in_chan.valid = 1'b0;
    in_chan.rx_byte = '0;
    out_chan.ready = 1'b0;

    // directed: plain data extremes and NUL
    add_rx(8'h41);
    add_rx(BYTE_NUL);
    add_rx(8'h80);
    add_rx(8'h7F);
    // escaped 0xFF, not rescanned
    add_rx(CMD_IAC);
    add_rx(CMD_IAC);
    // NUL after IAC and an unhandled command
    add_rx(CMD_IAC);
    add_rx(BYTE_NUL);
    add_rx(CMD_IAC);
    add_rx(8'hF1);
    // every negotiation command, option GA and extremes
    add_rx(CMD_IAC);
    add_rx(CMD_DO);
    add_rx(OPT_GA);
    add_rx(CMD_IAC);
    add_rx(CMD_DO);
    add_rx(8'h01);
    add_rx(CMD_IAC);
    add_rx(CMD_WILL);
    add_rx(OPT_GA);
    add_rx(CMD_IAC);
    add_rx(CMD_WONT);
    add_rx(BYTE_NUL);
    add_rx(CMD_IAC);
    add_rx(CMD_DONT);
    add_rx(CMD_IAC);

    // random: mostly well-formed sequences with random content
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        add_rx(BYTE_W'($urandom_range(1, 254)), sent == 0 || $urandom_range(99) < 2);
        sent++;
      end else if (kind < 43) begin
        add_rx(BYTE_NUL);
      end else if (kind < 53) begin
        add_rx(CMD_IAC);
        add_rx(CMD_IAC);
        sent += 2;
      end else if (kind < 80) begin
        add_rx(CMD_IAC, $urandom_range(99) < 3);
        add_rx(random_negotiation_cmd());
        add_rx(($urandom_range(99) < 25) ? OPT_GA : BYTE_W'($urandom_range(255)));
        sent += 3;
      end else if (kind < 92) begin
        add_rx(CMD_IAC);
        add_rx(BYTE_W'($urandom_range(255)));
        sent += 2;
      end else begin
        add_rx(BYTE_W'($urandom_range(255)));
        sent++;
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain stimulus, then results
    while (rx_stream.size() != 0 || in_chan.valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_TIME) @(posedge clk);

    if (expected_bytes.size() != 0)
      report_error($sformatf("%0d expected bytes never arrived", expected_bytes.size()));

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
